### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset disable and an error report.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication between two conditions.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication between two conditions.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

### hw/rtl/plgr_pkg.sv
// ----------------------------------------------------------------------------
// Levels and gamma remap package
// Widths, register codes and the constant tables of the log and power units.
// ----------------------------------------------------------------------------
package plgr_pkg;

  localparam int GAMMA_FRAC_BITS = 12;
  localparam int GAMMA_W         = 15;
  localparam int CH_W            = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 15;
  localparam int LOG_W           = 35;
  localparam int ROOT_W          = 32;
  localparam int NUM_POW         = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLACK = 2'd0,
    CFG_WHITE = 2'd1,
    CFG_GAMMA = 2'd2
  } cfg_idx_e;

  typedef logic [LOG_W-1:0]  log_tab_t  [256];
  typedef logic [ROOT_W-1:0] root_tab_t [NUM_POW+1];

  // Integer square root, bit pair by bit pair.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bit_v;
    logic [63:0] xv;
    res   = '0;
    xv    = x;
    bit_v = 64'd1 << 62;
    while (bit_v > xv) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (xv >= res + bit_v) begin
        xv  = xv - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // Base-2 log in Q.32 by repeated squaring of a Q1.30 mantissa.
  function automatic logic [LOG_W-1:0] log2_q32(input int unsigned x);
    int unsigned k;
    logic [63:0] m;
    logic [63:0] frac;
    k    = 0;
    frac = '0;
    while (k < 8 && (x >> (k + 1)) != 0) k++;
    m = 64'(x) << (30 - k);
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        frac[i] = 1'b1;
        m       = m >> 1;
      end
    end
    return LOG_W'((64'(k) << 32) | frac);
  endfunction

  function automatic log_tab_t make_log_tab();
    log_tab_t t;
    t[0] = '0;
    for (int i = 1; i < 256; i++) t[i] = log2_q32(i);
    return t;
  endfunction

  // Successive square roots of one half in Q31: weight 2^-i of the exponent.
  function automatic root_tab_t make_root_tab();
    root_tab_t t;
    logic [63:0] c;
    c    = 64'd1 << 30;
    t[0] = ROOT_W'(c);
    for (int i = 1; i <= NUM_POW; i++) begin
      c    = isqrt64(c << 31);
      t[i] = ROOT_W'(c);
    end
    return t;
  endfunction

  localparam log_tab_t  LOG2_TAB  = make_log_tab();
  localparam root_tab_t ROOT_TAB  = make_root_tab();

endpackage

### hw/rtl/plgr_if.sv
// ----------------------------------------------------------------------------
// Levels and gamma remap pixel channels
// Valid/ready channels for the input pixel and the remapped pixel.
// ----------------------------------------------------------------------------
interface plgr_in_if;
  logic                     valid;
  logic                     ready;
  logic [plgr_pkg::CH_W-1:0] red_in;
  logic [plgr_pkg::CH_W-1:0] green_in;
  logic [plgr_pkg::CH_W-1:0] blue_in;
  logic [plgr_pkg::CH_W-1:0] alpha_in;

  modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface plgr_out_if;
  logic                     valid;
  logic                     ready;
  logic [plgr_pkg::CH_W-1:0] red_out;
  logic [plgr_pkg::CH_W-1:0] green_out;
  logic [plgr_pkg::CH_W-1:0] blue_out;
  logic [plgr_pkg::CH_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

### hw/rtl/pixel_levels_gamma_remap_core.sv
// ----------------------------------------------------------------------------
// Pixel levels and gamma remap core
// Stretches each color channel between the black and white points and shapes
// it with a midtone gamma; alpha is copied through.
// ----------------------------------------------------------------------------
// The core takes one RGBA pixel per clock while input ready is high and
// returns one pixel per item, in order. Each color channel goes through a log
// table lookup, a restoring divider by the gamma that retires two quotient
// bits per stage, and a chain of 32 multiply stages that builds the fractional
// power of two. The stages feed a two-entry output buffer that lets the
// pipeline keep moving while a result waits; input ready drops only when
// both entries are full. Configuration must be written only while no item
// is in flight; the core does not enforce it.
module pixel_levels_gamma_remap_core #(
  parameter int GammaFracBits = plgr_pkg::GAMMA_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [plgr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [plgr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  plgr_in_if.sink                         pix_in,
  plgr_out_if.source                      pix_out
);
  import plgr_pkg::*;

  localparam int NumW      = LOG_W + GammaFracBits;
  localparam int DivStages = (NumW + 1) / 2;
  localparam int DvdW      = 2 * DivStages;
  localparam int NumStages = 1 + DivStages + NUM_POW;
  localparam int KHiW      = DvdW - 36;
  localparam logic [GAMMA_W-1:0] GammaMin =
    GAMMA_W'(((1 << GammaFracBits) + 99) / 100);

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [2:0]      zero;
    logic [2:0]      sat;
  } side_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } pix_t;

  // Configuration registers.
  logic [CH_W-1:0]    black_q, white_q;
  logic [GAMMA_W-1:0] gamma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_q <= '0;
      white_q <= '1;
      gamma_q <= GAMMA_W'(1 << GammaFracBits);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BLACK: black_q <= cfg_data_i[CH_W-1:0];
        CFG_WHITE: white_q <= cfg_data_i[CH_W-1:0];
        CFG_GAMMA: gamma_q <= cfg_data_i[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective span and gamma.
  logic [CH_W-1:0]    span;
  logic [GAMMA_W-1:0] g_eff;
  assign span  = (white_q <= black_q) ? CH_W'(1) : white_q - black_q;
  assign g_eff = (gamma_q < GammaMin) ? GammaMin : gamma_q;

  // Pipeline control and output buffer state.
  logic       en;
  logic [1:0] cnt_q;
  logic       vld_q  [NumStages];
  side_t      side_q [NumStages];

  assign en           = (cnt_q != 2'd2);
  assign pix_in.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumStages; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= pix_in.valid;
      for (int s = 1; s < NumStages; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Front stage: offset, range checks and log difference per channel.
  logic [CH_W-1:0]    chan_in [3];
  logic [DvdW-1:0]    dvd_q   [DivStages+1][3];
  logic [GAMMA_W-1:0] rem_q   [DivStages+1][3];
  side_t              side_d;
  logic [DvdW-1:0]    dvd0_d  [3];

  assign chan_in[0] = pix_in.red_in;
  assign chan_in[1] = pix_in.green_in;
  assign chan_in[2] = pix_in.blue_in;

  always_comb begin
    logic [CH_W-1:0]  n;
    logic [LOG_W-1:0] l;
    side_d.alpha = pix_in.alpha_in;
    for (int c = 0; c < 3; c++) begin
      n             = chan_in[c] - black_q;
      side_d.zero[c] = (chan_in[c] <= black_q);
      side_d.sat[c]  = (chan_in[c] > black_q) && (n >= span);
      l             = LOG2_TAB[span] - LOG2_TAB[n];
      dvd0_d[c]     = DvdW'(l) << GammaFracBits;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int c = 0; c < 3; c++) begin
        dvd_q[0][c] <= dvd0_d[c];
        rem_q[0][c] <= '0;
      end
    end
  end

  // Divider stages: two restoring quotient bits each.
  for (genvar j = 1; j <= DivStages; j++) begin : g_div
    logic [DvdW-1:0]    dvd_d [3];
    logic [GAMMA_W-1:0] rem_d [3];

    always_comb begin
      logic [GAMMA_W:0]   t;
      logic [GAMMA_W-1:0] r;
      logic [DvdW-1:0]    dv;
      for (int c = 0; c < 3; c++) begin
        r  = rem_q[j-1][c];
        dv = dvd_q[j-1][c];
        for (int s = 0; s < 2; s++) begin
          t  = {r, dv[DvdW-1]};
          dv = dv << 1;
          if (t >= {1'b0, g_eff}) begin
            t     = t - {1'b0, g_eff};
            dv[0] = 1'b1;
          end
          r = t[GAMMA_W-1:0];
        end
        dvd_d[c] = dv;
        rem_d[c] = r;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[j] <= side_q[j-1];
        for (int c = 0; c < 3; c++) begin
          dvd_q[j][c] <= dvd_d[c];
          rem_q[j][c] <= rem_d[c];
        end
      end
    end
  end

  // Power stages: one truncated root product per exponent fraction bit.
  logic [ROOT_W-1:0] r_q    [1:NUM_POW][3];
  logic [31:0]       frac_q [1:NUM_POW][3];
  logic [3:0]        k_q    [1:NUM_POW][3];

  for (genvar i = 1; i <= NUM_POW; i++) begin : g_pow
    logic [ROOT_W-1:0] r_prev [3];
    logic [31:0]       f_prev [3];
    logic [3:0]        k_prev [3];
    logic [ROOT_W-1:0] r_d    [3];
    side_t             side_in;

    if (i == 1) begin : g_first
      always_comb begin
        logic [DvdW-1:0] e;
        side_in = side_q[DivStages];
        for (int c = 0; c < 3; c++) begin
          e         = dvd_q[DivStages][c];
          r_prev[c] = ROOT_W'(64'd1 << 31);
          f_prev[c] = e[31:0];
          k_prev[c] = e[35:32];
          if ((e[DvdW-1:36] != KHiW'(0)) || (e[35:32] >= 4'd9)) begin
            side_in.zero[c] = 1'b1;
          end
        end
      end
    end else begin : g_rest
      always_comb begin
        side_in = side_q[DivStages+i-1];
        for (int c = 0; c < 3; c++) begin
          r_prev[c] = r_q[i-1][c];
          f_prev[c] = frac_q[i-1][c];
          k_prev[c] = k_q[i-1][c];
        end
      end
    end

    always_comb begin
      logic [63:0] prod;
      for (int c = 0; c < 3; c++) begin
        prod   = 64'(r_prev[c]) * 64'(ROOT_TAB[i]);
        r_d[c] = f_prev[c][NUM_POW-i] ? prod[62:31] : r_prev[c];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[DivStages+i] <= side_in;
        for (int c = 0; c < 3; c++) begin
          r_q[i][c]    <= r_d[c];
          frac_q[i][c] <= f_prev[c];
          k_q[i][c]    <= k_prev[c];
        end
      end
    end
  end

  // Final scaling, rounding and clamping into the output buffer.
  logic [CH_W-1:0] code [3];
  pix_t            res;

  always_comb begin
    logic [40:0] sum;
    logic [40:0] sh;
    for (int c = 0; c < 3; c++) begin
      sum = 41'd255 * 41'(r_q[NUM_POW][c]) + (41'd1 << (6'(k_q[NUM_POW][c]) + 6'd30));
      sh  = sum >> (6'(k_q[NUM_POW][c]) + 6'd31);
      if (side_q[NumStages-1].sat[c]) begin
        code[c] = '1;
      end else if (side_q[NumStages-1].zero[c]) begin
        code[c] = '0;
      end else if (sh > 41'd255) begin
        code[c] = '1;
      end else begin
        code[c] = sh[CH_W-1:0];
      end
    end
    res.red   = code[0];
    res.green = code[1];
    res.blue  = code[2];
    res.alpha = side_q[NumStages-1].alpha;
  end

  // Two-entry output buffer.
  pix_t buf_q [2];
  logic wr_q, rd_q;
  logic push, pop;

  assign push = en && vld_q[NumStages-1];
  assign pop  = pix_out.valid && pix_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= res;
  end

  assign pix_out.valid     = (cnt_q != 2'd0);
  assign pix_out.red_out   = buf_q[rd_q].red;
  assign pix_out.green_out = buf_q[rd_q].green;
  assign pix_out.blue_out  = buf_q[rd_q].blue;
  assign pix_out.alpha_out = buf_q[rd_q].alpha;

endmodule

### hw/rtl/plgr_checker.sv
// ----------------------------------------------------------------------------
// Levels and gamma remap checker
// Port-level assertions on the remap core's flow control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plgr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_data_i
);

  // A waiting result stays offered until it is taken.
  `ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "output item withdrawn")

  // A waiting result keeps its value.
  `ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_data_i), "output item changed")

  // Input back-pressure only ever comes from results waiting at the output.
  `ASSERT_IMP(a_stall_cause, !in_ready_i, out_valid_i, "input stalled with no result waiting")

  // With the buffer full and nothing taken, the input stays stalled.
  `ASSERT_NXT(a_stall_hold, !in_ready_i && !out_ready_i, !in_ready_i, "full buffer accepted an item")

endmodule

bind pixel_levels_gamma_remap_core plgr_checker u_plgr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_in.ready),
  .out_valid_i (pix_out.valid),
  .out_ready_i (pix_out.ready),
  .out_data_i  ({pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.alpha_out})
);

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Levels and gamma remap core testbench
// Drives RGBA pixels through the core under several level and gamma settings,
// predicts each remapped pixel with an integer log/power model of its own and
// compares every returned pixel field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import plgr_pkg::*;

  localparam int LATENCY = 58;
  localparam logic [63:0] Q31_ONE = 64'd1 << 31;
  localparam logic [63:0] GAMMA_FLOOR = ((64'd1 << GAMMA_FRAC_BITS) + 99) / 100;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  plgr_in_if  pix_in ();
  plgr_out_if pix_out ();

  pixel_levels_gamma_remap_core i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pix_in(pix_in.sink), .pix_out(pix_out.source)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the level and gamma registers.
  logic [7:0]  lvl_black = 8'd0;
  logic [7:0]  lvl_white = 8'd255;
  logic [14:0] lvl_gamma = 15'd4096;

  logic [63:0] half_roots [33];
  pixel_t remap_queue [$];
  int errors = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  bit stall_on = 1'b1;

  function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_fixed(input logic [63:0] x);
    logic [63:0] k, m, frac;
    k = 0;
    frac = 0;
    while (k < 8 && (x >> (k + 1)) != 0) k++;
    m = x << (30 - k);
    for (int i = 31; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= Q31_ONE) begin
        frac[i] = 1'b1;
        m = m >> 1;
      end
    end
    return (k << 32) | frac;
  endfunction

  // Remaps one color channel against the current levels.
  function automatic logic [7:0] level_channel(input logic [7:0] v);
    logic [63:0] b, w, d, g, n, ln, ex, k, f, r;
    b = 64'(lvl_black);
    w = 64'(lvl_white);
    g = 64'(lvl_gamma);
    if (w <= b) w = b + 1;
    d = w - b;
    if (g < GAMMA_FLOOR) g = GAMMA_FLOOR;
    if (64'(v) <= b) return 8'd0;
    n = 64'(v) - b;
    if (n >= d) return 8'd255;
    ln = log2_fixed(d) - log2_fixed(n);
    ex = (ln << GAMMA_FRAC_BITS) / g;
    k = ex >> 32;
    if (k >= 9) return 8'd0;
    f = ex & 64'hFFFF_FFFF;
    r = Q31_ONE;
    for (int i = 1; i <= 32; i++) begin
      if (f[32-i]) r = (r * half_roots[i]) >> 31;
    end
    r = (255 * r + (64'd1 << (30 + k))) >> (31 + k);
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // Writes one register between phases.
  task automatic write_level(input cfg_idx_e idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_BLACK: lvl_black = value[7:0];
      CFG_WHITE: lvl_white = value[7:0];
      CFG_GAMMA: lvl_gamma = value[14:0];
      default: ;
    endcase
  endtask

  task automatic set_levels(input int unsigned b, input int unsigned w, input int unsigned g);
    write_level(CFG_BLACK, b);
    write_level(CFG_WHITE, w);
    write_level(CFG_GAMMA, g);
  endtask

  // Sends one pixel and records its expected remap at acceptance.
  task automatic send_pixel(input pixel_t px);
    pixel_t exp_px;
    pix_in.valid <= 1'b1;
    pix_in.red_in <= px.red;
    pix_in.green_in <= px.green;
    pix_in.blue_in <= px.blue;
    pix_in.alpha_in <= px.alpha;
    do @(posedge clk_i); while (!pix_in.ready);
    exp_px.red = level_channel(px.red);
    exp_px.green = level_channel(px.green);
    exp_px.blue = level_channel(px.blue);
    exp_px.alpha = px.alpha;
    remap_queue.push_back(exp_px);
    pixels_sent++;
  endtask

  task automatic idle_gap(input int unsigned cycles);
    pix_in.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Waits for every pixel to return, then lets the pipeline drain.
  task automatic drain;
    idle_gap(1);
    while (remap_queue.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic pixel_t rand_pixel();
    return pixel_t'($urandom);
  endfunction

  // Random pixels, red put near the black point and green near the white point, each half of the time.
  function automatic pixel_t edge_pixel();
    pixel_t p;
    p = rand_pixel();
    if ($urandom_range(1)) p.red = 8'(lvl_black + $urandom_range(3) - 1);
    if ($urandom_range(1)) p.green = 8'(lvl_white + $urandom_range(3) - 1);
    return p;
  endfunction

  task automatic test_directed;
    set_levels(0, 255, 4096);
    send_pixel({8'd0, 8'd255, 8'd128, 8'd0});
    send_pixel({8'd255, 8'd0, 8'd1, 8'd255});
    send_pixel({8'd254, 8'd127, 8'd64, 8'hA5});
    drain();
    set_levels(40, 200, 410);
    send_pixel({8'd40, 8'd41, 8'd199, 8'd200});
    send_pixel({8'd0, 8'd120, 8'd255, 8'h5A});
    drain();
    set_levels(10, 250, 20480);
    send_pixel({8'd11, 8'd12, 8'd30, 8'd1});
    send_pixel({8'd100, 8'd249, 8'd251, 8'd2});
    drain();
    // White at or below black: every color channel maps to an extreme.
    set_levels(100, 90, 4096);
    send_pixel({8'd100, 8'd101, 8'd99, 8'd3});
    drain();
    set_levels(255, 255, 4096);
    send_pixel({8'd255, 8'd0, 8'd254, 8'd4});
    drain();
    // Gamma below the floor, zero included, and at its largest code.
    set_levels(0, 255, 0);
    send_pixel({8'd1, 8'd128, 8'd254, 8'd5});
    drain();
    set_levels(0, 255, 20);
    send_pixel({8'd2, 8'd200, 8'd250, 8'd6});
    drain();
    set_levels(0, 255, 32767);
    send_pixel({8'd1, 8'd2, 8'd254, 8'd7});
    send_pixel({8'd127, 8'd128, 8'd200, 8'd8});
    drain();
  endtask

  task automatic test_random(input int unsigned num_phases, input int unsigned per_phase);
    int unsigned left, burst;
    for (int ph = 0; ph < num_phases; ph++) begin
      case (ph % 4)
        0: set_levels($urandom_range(254), $urandom_range(255, 1), $urandom_range(20480, 410));
        1: set_levels($urandom_range(30), $urandom_range(255, 225), $urandom_range(2048, 410));
        2: set_levels($urandom_range(255), $urandom_range(255), $urandom_range(32767));
        default: set_levels(0, 255, $urandom_range(20480, 8192));
      endcase
      stall_on = (ph % 3 != 0);
      left = per_phase;
      while (left > 0) begin
        burst = $urandom_range(24, 1);
        if (burst > left) burst = left;
        repeat (burst) send_pixel(($urandom_range(2) == 0) ? edge_pixel() : rand_pixel());
        left -= burst;
        if (stall_on && $urandom_range(1)) idle_gap($urandom_range(6, 1));
      end
      drain();
    end
  endtask

  // Receiver stalls, while stall_on is set, on a shifting pattern with random feedback.
  logic [15:0] stall_pattern = 16'b1011_0011_1000_1111;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else begin
      stall_pattern <= {stall_pattern[14:0], stall_pattern[15] ^ 1'($urandom_range(1))};
      pix_out.ready <= !stall_on || stall_pattern[0] || stall_pattern[3];
    end
  end

  // Compares each returned pixel with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_t exp_px, got_px;
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      got_px = {pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.alpha_out};
      if (remap_queue.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, got_px);
        errors++;
      end else begin
        exp_px = remap_queue.pop_front();
        pixels_checked++;
        if (exp_px.red !== got_px.red) begin
          $display("%0t: red expected %0d actual %0d", $time, exp_px.red, got_px.red);
          errors++;
        end
        if (exp_px.green !== got_px.green) begin
          $display("%0t: green expected %0d actual %0d", $time, exp_px.green, got_px.green);
          errors++;
        end
        if (exp_px.blue !== got_px.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, exp_px.blue, got_px.blue);
          errors++;
        end
        if (exp_px.alpha !== got_px.alpha) begin
          $display("%0t: alpha expected %0d actual %0d", $time, exp_px.alpha, got_px.alpha);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    half_roots[0] = 64'd1 << 30;
    for (int i = 1; i <= 32; i++) half_roots[i] = sqrt_floor(half_roots[i-1] << 31);
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    pix_in.alpha_in = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random(12, 80);
    $display("Sent %0d pixels, checked %0d, over directed and 12 random level settings.",
             pixels_sent, pixels_checked);
    if (errors == 0 && remap_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
